FILE: rtl/core/tvt_pkg.sv
package tvt_pkg;

  // Default geometry of the datapath
  localparam int COORD_BITS_DEF      = 12;
  localparam int TRIG_FRAC_BITS_DEF  = 14;
  localparam int SCALE_FRAC_BITS_DEF = 8;

  // Pipeline shape
  localparam int NUM_LANES    = 3;
  localparam int LANE_STAGES  = 6;
  localparam int MERGE_STAGES = 2;
  localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

  // Field widths
  localparam int SCR_BITS  = 16;
  localparam int SURF_BITS = 13;
  localparam int BOX_BITS  = 17;
  localparam int CFG_BITS  = 16;
  localparam int ADDR_BITS = 3;

  // Register indexes
  localparam logic [ADDR_BITS-1:0] REG_SCALE  = 3'd0;
  localparam logic [ADDR_BITS-1:0] REG_COS    = 3'd1;
  localparam logic [ADDR_BITS-1:0] REG_SIN    = 3'd2;
  localparam logic [ADDR_BITS-1:0] REG_SHX    = 3'd3;
  localparam logic [ADDR_BITS-1:0] REG_SHY    = 3'd4;
  localparam logic [ADDR_BITS-1:0] REG_SURF_W = 3'd5;
  localparam logic [ADDR_BITS-1:0] REG_SURF_H = 3'd6;

  // Register reset values
  localparam logic [CFG_BITS-1:0]  RST_SCALE  = 16'd256;
  localparam logic [CFG_BITS-1:0]  RST_COS    = 16'd16384;
  localparam logic [CFG_BITS-1:0]  RST_SIN    = 16'd0;
  localparam logic [CFG_BITS-1:0]  RST_SHX    = 16'd0;
  localparam logic [CFG_BITS-1:0]  RST_SHY    = 16'd0;
  localparam logic [SURF_BITS-1:0] RST_SURF_W = 13'd640;
  localparam logic [SURF_BITS-1:0] RST_SURF_H = 13'd480;

  // Transform settings shared by all lanes
  typedef struct packed {
    logic [CFG_BITS-1:0] scale;
    logic [CFG_BITS-1:0] cos_term;
    logic [CFG_BITS-1:0] sin_term;
    logic [CFG_BITS-1:0] shx;
    logic [CFG_BITS-1:0] shy;
  } xcfg_t;

  // Surface bounds for the merge stage
  typedef struct packed {
    logic [SURF_BITS-1:0] width;
    logic [SURF_BITS-1:0] height;
  } surf_t;

endpackage

FILE: rtl/core/triangle_vertex_transform.sv
// Triangle vertex transform: each accepted triangle (three signed model
// vertices) is scaled by an unsigned Q8.8 factor, rotated by the loaded Q2.14
// cosine and sine, translated and saturated to 16 bits, with both fraction
// drops truncating toward zero. The result carries the six screen coordinates,
// the bounding box corner and size, and a flag set when every vertex lies on
// the surface. Three identical vertex lanes of six stages each feed a two-stage
// merge, so one triangle can be taken every cycle while the output is not
// stalled; its result passes the six lane and two merge registers. Stages that
// hold no triangle let the pipe close up, so a stalled output only blocks the
// input once all eight stages are full. Registers are written through the cfg_
// port and must only change while no triangle is in flight.
module triangle_vertex_transform #(
  parameter int COORD_BITS      = tvt_pkg::COORD_BITS_DEF,
  parameter int TRIG_FRAC_BITS  = tvt_pkg::TRIG_FRAC_BITS_DEF,
  parameter int SCALE_FRAC_BITS = tvt_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                cfg_we,
  input  logic [tvt_pkg::ADDR_BITS-1:0]       cfg_addr,
  input  logic [tvt_pkg::CFG_BITS-1:0]        cfg_wdata,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_ax,
  input  logic signed [COORD_BITS-1:0]        in_ay,
  input  logic signed [COORD_BITS-1:0]        in_bx,
  input  logic signed [COORD_BITS-1:0]        in_by_coord,
  input  logic signed [COORD_BITS-1:0]        in_cx,
  input  logic signed [COORD_BITS-1:0]        in_cy,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tvt_pkg::SCR_BITS-1:0] out_screen_ax,
  output logic signed [tvt_pkg::SCR_BITS-1:0] out_screen_ay,
  output logic signed [tvt_pkg::SCR_BITS-1:0] out_screen_bx,
  output logic signed [tvt_pkg::SCR_BITS-1:0] out_screen_by,
  output logic signed [tvt_pkg::SCR_BITS-1:0] out_screen_cx,
  output logic signed [tvt_pkg::SCR_BITS-1:0] out_screen_cy,
  output logic signed [tvt_pkg::SCR_BITS-1:0] out_box_left,
  output logic signed [tvt_pkg::SCR_BITS-1:0] out_box_top,
  output logic [tvt_pkg::BOX_BITS-1:0]        out_box_width,
  output logic [tvt_pkg::BOX_BITS-1:0]        out_box_height,
  output logic                                out_inside_surface
);

  localparam int NS = tvt_pkg::PIPE_STAGES;
  localparam int LS = tvt_pkg::LANE_STAGES;
  localparam int NL = tvt_pkg::NUM_LANES;
  localparam int SB = tvt_pkg::SCR_BITS;
  localparam int FB = tvt_pkg::SURF_BITS;

  // Configuration registers
  logic [tvt_pkg::CFG_BITS-1:0] scale_r, cos_r, sin_r, shx_r, shy_r;
  logic [FB-1:0]                surf_w_r, surf_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= tvt_pkg::RST_SCALE;
      cos_r    <= tvt_pkg::RST_COS;
      sin_r    <= tvt_pkg::RST_SIN;
      shx_r    <= tvt_pkg::RST_SHX;
      shy_r    <= tvt_pkg::RST_SHY;
      surf_w_r <= tvt_pkg::RST_SURF_W;
      surf_h_r <= tvt_pkg::RST_SURF_H;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tvt_pkg::REG_SCALE:  scale_r  <= cfg_wdata;
        tvt_pkg::REG_COS:    cos_r    <= cfg_wdata;
        tvt_pkg::REG_SIN:    sin_r    <= cfg_wdata;
        tvt_pkg::REG_SHX:    shx_r    <= cfg_wdata;
        tvt_pkg::REG_SHY:    shy_r    <= cfg_wdata;
        tvt_pkg::REG_SURF_W: surf_w_r <= cfg_wdata[FB-1:0];
        tvt_pkg::REG_SURF_H: surf_h_r <= cfg_wdata[FB-1:0];
        default: ;
      endcase
    end
  end

  tvt_pkg::xcfg_t xcfg;
  tvt_pkg::surf_t surf;

  assign xcfg = '{scale: scale_r, cos_term: cos_r, sin_term: sin_r,
                  shx: shx_r, shy: shy_r};
  assign surf = '{width: surf_w_r, height: surf_h_r};

  // Pipeline control: a stage loads when empty or when its successor moves
  logic [NS-1:0] vld_r;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NS-1];

  // Vertex lanes
  logic signed [COORD_BITS-1:0] vx [NL];
  logic signed [COORD_BITS-1:0] vy [NL];
  logic [NL-1:0][SB-1:0]        lane_px, lane_py;
  logic [NL-1:0][SB-1:0]        scr_px, scr_py;

  assign vx[0] = in_ax;
  assign vy[0] = in_ay;
  assign vx[1] = in_bx;
  assign vy[1] = in_by_coord;
  assign vx[2] = in_cx;
  assign vy[2] = in_cy;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    tvt_lane #(
      .COORD_BITS      (COORD_BITS),
      .TRIG_FRAC_BITS  (TRIG_FRAC_BITS),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (en[LS-1:0]),
      .xcfg   (xcfg),
      .x_in   (vx[g]),
      .y_in   (vy[g]),
      .px_out (lane_px[g]),
      .py_out (lane_py[g])
    );
  end

  // Bounding box and surface check
  tvt_merge u_merge (
    .clk        (clk),
    .en         (en[NS-1:LS]),
    .surf       (surf),
    .px_in      (lane_px),
    .py_in      (lane_py),
    .px_out     (scr_px),
    .py_out     (scr_py),
    .left_out   (out_box_left),
    .top_out    (out_box_top),
    .width_out  (out_box_width),
    .height_out (out_box_height),
    .inside_out (out_inside_surface)
  );

  assign out_screen_ax = scr_px[0];
  assign out_screen_ay = scr_py[0];
  assign out_screen_bx = scr_px[1];
  assign out_screen_by = scr_py[1];
  assign out_screen_cx = scr_px[2];
  assign out_screen_cy = scr_py[2];

`ifndef SYNTHESIS
  // Input is only held off when every stage holds a triangle
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r) && out_stall)
    else $error("input stalled with room in the pipeline");

  // A box always spans at least one pixel
  a_box_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_box_width != '0 && out_box_height != '0)
    else $error("zero box size");

  // On-surface triangles have a non-negative corner
  a_inside_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_surface |-> !out_box_left[SB-1] && !out_box_top[SB-1])
    else $error("inside flag with negative box corner");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

FILE: rtl/core/tvt_lane.sv
module tvt_lane #(
  parameter int COORD_BITS      = tvt_pkg::COORD_BITS_DEF,
  parameter int TRIG_FRAC_BITS  = tvt_pkg::TRIG_FRAC_BITS_DEF,
  parameter int SCALE_FRAC_BITS = tvt_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic [tvt_pkg::LANE_STAGES-1:0]     en,
  input  tvt_pkg::xcfg_t                      xcfg,
  input  logic signed [COORD_BITS-1:0]        x_in,
  input  logic signed [COORD_BITS-1:0]        y_in,
  output logic signed [tvt_pkg::SCR_BITS-1:0] px_out,
  output logic signed [tvt_pkg::SCR_BITS-1:0] py_out
);

  // Widths: scaled product, scaled coordinate, trig product, rotated sum,
  // rotated quotient and translated sum
  localparam int PW  = COORD_BITS + tvt_pkg::CFG_BITS + 1;
  localparam int SW  = PW - SCALE_FRAC_BITS;
  localparam int MW  = SW + tvt_pkg::CFG_BITS;
  localparam int RW  = MW + 1;
  localparam int RQ  = RW - TRIG_FRAC_BITS;
  localparam int AW  = ((RQ > tvt_pkg::SCR_BITS) ? RQ : tvt_pkg::SCR_BITS) + 1;

  localparam logic signed [PW-1:0] SBIAS  = PW'((1 << SCALE_FRAC_BITS) - 1);
  localparam logic signed [RW-1:0] TBIAS  = RW'((1 << TRIG_FRAC_BITS) - 1);
  localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
  localparam logic signed [AW-1:0] SAT_LO = -AW'(32768);

  // Stage 1: scale multiply
  logic signed [PW-1:0] x_ext, y_ext, s_ext;
  logic signed [PW-1:0] prod_x_r, prod_y_r;

  assign x_ext = PW'(x_in);
  assign y_ext = PW'(y_in);
  assign s_ext = PW'($signed({1'b0, xcfg.scale}));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_x_r <= x_ext * s_ext;
      prod_y_r <= y_ext * s_ext;
    end
  end

  // Stage 2: drop scale fraction, truncating toward zero
  logic signed [PW-1:0] bx_sum, by_sum;
  logic signed [PW-1:0] bx_shr, by_shr;
  logic signed [SW-1:0] sx_r, sy_r;

  assign bx_sum = prod_x_r + (prod_x_r[PW-1] ? SBIAS : '0);
  assign by_sum = prod_y_r + (prod_y_r[PW-1] ? SBIAS : '0);
  assign bx_shr = bx_sum >>> SCALE_FRAC_BITS;
  assign by_shr = by_sum >>> SCALE_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sx_r <= bx_shr[SW-1:0];
      sy_r <= by_shr[SW-1:0];
    end
  end

  // Stage 3: rotation products
  logic signed [MW-1:0] sx_ext, sy_ext, c_ext, n_ext;
  logic signed [MW-1:0] p_xc_r, p_yn_r, p_xn_r, p_yc_r;

  assign sx_ext = MW'(sx_r);
  assign sy_ext = MW'(sy_r);
  assign c_ext  = MW'($signed(xcfg.cos_term));
  assign n_ext  = MW'($signed(xcfg.sin_term));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p_xc_r <= sx_ext * c_ext;
      p_yn_r <= sy_ext * n_ext;
      p_xn_r <= sx_ext * n_ext;
      p_yc_r <= sy_ext * c_ext;
    end
  end

  // Stage 4: rotation sums
  logic signed [RW-1:0] rx_sum_r, ry_sum_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rx_sum_r <= RW'(p_xc_r) - RW'(p_yn_r);
      ry_sum_r <= RW'(p_xn_r) + RW'(p_yc_r);
    end
  end

  // Stage 5: drop trig fraction, truncating toward zero
  logic signed [RW-1:0] tx_sum, ty_sum;
  logic signed [RW-1:0] tx_shr, ty_shr;
  logic signed [RQ-1:0] rq_x_r, rq_y_r;

  assign tx_sum = rx_sum_r + (rx_sum_r[RW-1] ? TBIAS : '0);
  assign ty_sum = ry_sum_r + (ry_sum_r[RW-1] ? TBIAS : '0);
  assign tx_shr = tx_sum >>> TRIG_FRAC_BITS;
  assign ty_shr = ty_sum >>> TRIG_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      rq_x_r <= tx_shr[RQ-1:0];
      rq_y_r <= ty_shr[RQ-1:0];
    end
  end

  // Stage 6: translate and saturate to 16 bits
  logic signed [AW-1:0] ax_sum, ay_sum;
  logic signed [tvt_pkg::SCR_BITS-1:0] px_nxt, py_nxt;
  logic signed [tvt_pkg::SCR_BITS-1:0] px_r, py_r;

  assign ax_sum = AW'(rq_x_r) + AW'($signed(xcfg.shx));
  assign ay_sum = AW'(rq_y_r) + AW'($signed(xcfg.shy));

  always_comb begin
    priority if (ax_sum > SAT_HI) px_nxt = 16'sh7fff;
    else if (ax_sum < SAT_LO)     px_nxt = 16'sh8000;
    else                          px_nxt = ax_sum[tvt_pkg::SCR_BITS-1:0];
    priority if (ay_sum > SAT_HI) py_nxt = 16'sh7fff;
    else if (ay_sum < SAT_LO)     py_nxt = 16'sh8000;
    else                          py_nxt = ay_sum[tvt_pkg::SCR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
  end

  assign px_out = px_r;
  assign py_out = py_r;

endmodule

FILE: rtl/core/tvt_merge.sv
module tvt_merge (
  input  logic                                                   clk,
  input  logic [tvt_pkg::MERGE_STAGES-1:0]                       en,
  input  tvt_pkg::surf_t                                         surf,
  input  logic [tvt_pkg::NUM_LANES-1:0][tvt_pkg::SCR_BITS-1:0]   px_in,
  input  logic [tvt_pkg::NUM_LANES-1:0][tvt_pkg::SCR_BITS-1:0]   py_in,
  output logic [tvt_pkg::NUM_LANES-1:0][tvt_pkg::SCR_BITS-1:0]   px_out,
  output logic [tvt_pkg::NUM_LANES-1:0][tvt_pkg::SCR_BITS-1:0]   py_out,
  output logic [tvt_pkg::SCR_BITS-1:0]                           left_out,
  output logic [tvt_pkg::SCR_BITS-1:0]                           top_out,
  output logic [tvt_pkg::BOX_BITS-1:0]                           width_out,
  output logic [tvt_pkg::BOX_BITS-1:0]                           height_out,
  output logic                                                   inside_out
);

  localparam int SB = tvt_pkg::SCR_BITS;
  localparam int NL = tvt_pkg::NUM_LANES;

  // Stage 1: extremes and bounds check across lanes
  logic signed [SB-1:0] min_x, max_x, min_y, max_y;
  logic                 inside_nxt;
  logic signed [SB-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic                 inside_r;
  logic [NL-1:0][SB-1:0] px_r, py_r;

  always_comb begin
    min_x = $signed(px_in[0]);
    max_x = $signed(px_in[0]);
    min_y = $signed(py_in[0]);
    max_y = $signed(py_in[0]);
    inside_nxt = 1'b1;
    for (int i = 0; i < NL; i++) begin
      if ($signed(px_in[i]) < min_x) min_x = $signed(px_in[i]);
      if ($signed(px_in[i]) > max_x) max_x = $signed(px_in[i]);
      if ($signed(py_in[i]) < min_y) min_y = $signed(py_in[i]);
      if ($signed(py_in[i]) > max_y) max_y = $signed(py_in[i]);
      // on surface: non-negative and below the size
      if (px_in[i][SB-1] || (px_in[i][SB-2:0] >= (SB-1)'(surf.width)))
        inside_nxt = 1'b0;
      if (py_in[i][SB-1] || (py_in[i][SB-2:0] >= (SB-1)'(surf.height)))
        inside_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_r     <= px_in;
      py_r     <= py_in;
      min_x_r  <= min_x;
      max_x_r  <= max_x;
      min_y_r  <= min_y;
      max_y_r  <= max_y;
      inside_r <= inside_nxt;
    end
  end

  // Stage 2: box size, output register
  localparam int BB = tvt_pkg::BOX_BITS;
  logic [NL-1:0][SB-1:0] px_o_r, py_o_r;
  logic [SB-1:0]         left_r, top_r;
  logic [BB-1:0]         width_r, height_r;
  logic                  inside_o_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px_o_r     <= px_r;
      py_o_r     <= py_r;
      left_r     <= min_x_r;
      top_r      <= min_y_r;
      width_r    <= BB'(BB'(max_x_r) - BB'(min_x_r) + BB'(1));
      height_r   <= BB'(BB'(max_y_r) - BB'(min_y_r) + BB'(1));
      inside_o_r <= inside_r;
    end
  end

  assign px_out     = px_o_r;
  assign py_out     = py_o_r;
  assign left_out   = left_r;
  assign top_out    = top_r;
  assign width_out  = width_r;
  assign height_out = height_r;
  assign inside_out = inside_o_r;

endmodule
